// File: sv/rmig_pkg.sv
// Shared types and constants for the revolution mesh index generator.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package rmig_pkg;

    localparam int MAX_PROFILE   = 64;
    localparam int MAX_INSTANCES = 256;

    localparam int P_W    = 7;   // profile_points register
    localparam int N_W    = 9;   // instance_count register
    localparam int INST_W = 8;   // instance walk index
    localparam int SEG_W  = 6;   // segment walk index
    localparam int IDX_W  = 15;  // vertex index width
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_PROFILE_POINTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INSTANCE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAPS_ENABLE    = 2'd2;

    typedef enum logic [1:0] {
        PH_BAND   = 2'd0,
        PH_BOTTOM = 2'd1,
        PH_TOP    = 2'd2
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic [INST_W-1:0]  inst;
        logic [SEG_W-1:0]   seg;
        logic               half;
    } t_walk;

    // clamped configuration as the datapath sees it
    typedef struct packed {
        logic [P_W-1:0]  p;
        logic [N_W-1:0]  n;
        logic            caps;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] c0;
        logic [IDX_W-1:0] c1;
        logic [IDX_W-1:0] c2;
        logic             odd;
        logic             is_cap;
        logic             last;
    } t_tri;

endpackage

// File: sv/rmig_step_if.sv
// Input channel: valid/ready handshake carrying the restart flag.
// Self-contained; no package dependency.
`timescale 1ns / 1ps

interface rmig_step_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

// File: sv/rmig_tri_if.sv
// Result channel: valid/ready handshake carrying one triangle per beat.
// Depends on rmig_pkg for the index width.
`timescale 1ns / 1ps

interface rmig_tri_if;
    logic                        valid;
    logic                        ready;
    logic [rmig_pkg::IDX_W-1:0]  corner_first;
    logic [rmig_pkg::IDX_W-1:0]  corner_second;
    logic [rmig_pkg::IDX_W-1:0]  corner_third;
    logic                        odd_face;
    logic                        is_cap;
    logic                        last_face;

    modport source (output valid, output corner_first, output corner_second,
                    output corner_third, output odd_face, output is_cap,
                    output last_face, input ready);
    modport sink   (input valid, input corner_first, input corner_second,
                    input corner_third, input odd_face, input is_cap,
                    input last_face, output ready);
endinterface

// File: sv/revolution_mesh_index_generator.sv
// Revolution mesh index generator: one triangle index triple per input beat.
// The triangle appears on o_tri the cycle after the beat is taken.
// Throughput 1 beat per cycle while o_tri is ready; the output register frees in the same cycle it drains.
// Synchronous active-low reset: walk at first band triangle, output empty,
// registers at profile_points 2, instance_count 3, caps off.
// Depends on rmig_pkg, rmig_step_if, rmig_tri_if, rmig_tri_calc.
`timescale 1ns / 1ps

module revolution_mesh_index_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rmig_step_if.sink                       i_step,
    rmig_tri_if.source                      o_tri,
    input  logic                            i_cfg_we,
    input  logic [rmig_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rmig_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rmig_pkg::*;

    // configuration registers, raw as written
    logic [P_W-1:0] r_profile_points;
    logic [N_W-1:0] r_instance_count;
    logic           r_caps_enable;

    // walk position and output stage
    t_walk r_walk;
    t_walk n_walk;
    t_walk cur;      // walk position after restart and sanity clears
    t_cfg  cfg;
    t_tri  tri_c;
    t_tri  r_out;
    logic  r_out_valid;

    logic  in_acc;
    logic  cfg_hit;
    logic  inst_last;
    logic  seg_last;
    logic [P_W-1:0] p_m2;

    // ---------------- configuration ----------------
    assign cfg_hit = i_cfg_we && (i_cfg_idx == REG_PROFILE_POINTS
                               || i_cfg_idx == REG_INSTANCE_COUNT
                               || i_cfg_idx == REG_CAPS_ENABLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_profile_points <= P_W'(2);
            r_instance_count <= N_W'(3);
            r_caps_enable    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PROFILE_POINTS: r_profile_points <= i_cfg_data[P_W-1:0];
                REG_INSTANCE_COUNT: r_instance_count <= i_cfg_data[N_W-1:0];
                REG_CAPS_ENABLE:    r_caps_enable    <= i_cfg_data[0];
                default: ;          // unmapped index: ignored
            endcase
        end
    end

    // clamp to the supported mesh size
    always_comb begin
        cfg.caps = r_caps_enable;
        if (r_profile_points < P_W'(2))
            cfg.p = P_W'(2);
        else if (r_profile_points > P_W'(MAX_PROFILE))
            cfg.p = P_W'(MAX_PROFILE);
        else
            cfg.p = r_profile_points;
        if (r_instance_count < N_W'(2))
            cfg.n = N_W'(2);
        else if (r_instance_count > N_W'(MAX_INSTANCES))
            cfg.n = N_W'(MAX_INSTANCES);
        else
            cfg.n = r_instance_count;
    end

    // ---------------- handshake ----------------
    // Output register acts as the only stage; it can take a new beat
    // whenever it is empty or being drained this cycle.
    assign i_step.ready = !r_out_valid || o_tri.ready;
    assign in_acc       = i_step.valid && i_step.ready;

    // ---------------- walk: current position ----------------
    always_comb begin
        cur = r_walk;
        if (i_step.restart || !(r_walk.phase == PH_BAND
                             || r_walk.phase == PH_BOTTOM
                             || r_walk.phase == PH_TOP))
            cur = '{phase: PH_BAND, inst: '0, seg: '0, half: 1'b0};
        if (!cfg.caps && cur.phase != PH_BAND)
            cur = '{phase: PH_BAND, inst: '0, seg: '0, half: 1'b0};
        if ({1'b0, cur.inst} >= cfg.n)
            cur.inst = '0;
        if ({1'b0, cur.seg} > p_m2)
            cur.seg = '0;
    end

    assign p_m2      = cfg.p - P_W'(2);
    assign inst_last = ({1'b0, cur.inst} == (cfg.n - N_W'(1)));
    assign seg_last  = ({1'b0, cur.seg} == p_m2);

    // ---------------- walk: next position ----------------
    always_comb begin
        n_walk = cur;
        case (cur.phase)
            PH_BAND: begin
                if (!cur.half) begin
                    n_walk.half = 1'b1;
                end else begin
                    n_walk.half = 1'b0;
                    if (!seg_last) begin
                        n_walk.seg = cur.seg + SEG_W'(1);
                    end else begin
                        n_walk.seg = '0;
                        if (!inst_last) begin
                            n_walk.inst = cur.inst + INST_W'(1);
                        end else begin
                            // band done: caps follow if enabled, else wrap
                            n_walk.inst  = '0;
                            n_walk.phase = cfg.caps ? PH_BOTTOM : PH_BAND;
                        end
                    end
                end
            end
            PH_BOTTOM, PH_TOP: begin
                if (!inst_last) begin
                    n_walk.inst = cur.inst + INST_W'(1);
                end else begin
                    n_walk.inst  = '0;
                    n_walk.phase = (cur.phase == PH_BOTTOM) ? PH_TOP : PH_BAND;
                end
            end
            default: begin
                n_walk = '{phase: PH_BAND, inst: '0, seg: '0, half: 1'b0};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            // any register write restarts the mesh
            r_walk <= '{phase: PH_BAND, inst: '0, seg: '0, half: 1'b0};
        end else if (in_acc) begin
            r_walk <= n_walk;
        end
    end

    // ---------------- corner arithmetic ----------------
    rmig_tri_calc u_calc (
        .i_walk (cur),
        .i_cfg  (cfg),
        .o_tri  (tri_c)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_tri.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= tri_c;
        end
    end

    assign o_tri.valid         = r_out_valid;
    assign o_tri.corner_first  = r_out.c0;
    assign o_tri.corner_second = r_out.c1;
    assign o_tri.corner_third  = r_out.c2;
    assign o_tri.odd_face      = r_out.odd;
    assign o_tri.is_cap        = r_out.is_cap;
    assign o_tri.last_face     = r_out.last;

    // ---------------- assertions ----------------
    // a restart beat always yields the first band triangle, starting at vertex 0
    a_restart_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_step.restart |=>
            r_out.c0 == '0 && !r_out.is_cap && !r_out.odd)
        else $error("restart did not produce the first band triangle");

    // after the final triangle the walk is back at the start
    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && tri_c.last && !cfg_hit |=>
            r_walk.phase == PH_BAND && r_walk.inst == '0
            && r_walk.seg == '0 && !r_walk.half)
        else $error("walk did not wrap after the last triangle");

    // with caps off no cap triangle is produced
    a_no_caps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !r_caps_enable |=> !r_out.is_cap)
        else $error("cap triangle produced with caps disabled");

endmodule

// File: sv/rmig_tri_calc.sv
// Triangle corner arithmetic for one walk position.
// Depends on rmig_pkg (walk, config and triangle structs).
`timescale 1ns / 1ps

module rmig_tri_calc (
    input  rmig_pkg::t_walk i_walk,
    input  rmig_pkg::t_cfg  i_cfg,
    output rmig_pkg::t_tri  o_tri
);
    import rmig_pkg::*;

    logic              inst_last;
    logic [INST_W-1:0] nxt;
    logic [IDX_W-1:0]  base_i;
    logic [IDX_W-1:0]  base_n;
    logic [IDX_W:0]    pole_full;
    logic [IDX_W-1:0]  pole;
    logic [IDX_W-1:0]  a;
    logic [IDX_W-1:0]  b;
    logic [IDX_W-1:0]  p_x;
    logic [P_W-1:0]    p_m2;

    assign inst_last = ({1'b0, i_walk.inst} == (i_cfg.n - N_W'(1)));
    assign nxt       = inst_last ? '0 : i_walk.inst + INST_W'(1);
    assign p_x       = IDX_W'(i_cfg.p);
    assign p_m2      = i_cfg.p - P_W'(2);

    assign base_i    = p_x * IDX_W'(i_walk.inst);
    assign base_n    = p_x * IDX_W'(nxt);
    assign pole_full = (IDX_W + 1)'(i_cfg.p) * (IDX_W + 1)'(i_cfg.n);
    assign pole      = pole_full[IDX_W-1:0];

    assign a = base_i + IDX_W'(i_walk.seg);
    assign b = base_n + IDX_W'(i_walk.seg);

    always_comb begin
        o_tri = '0;
        case (i_walk.phase)
            PH_BAND: begin
                o_tri.c0     = a;
                o_tri.c1     = i_walk.half ? b + IDX_W'(1) : b;
                o_tri.c2     = i_walk.half ? a + IDX_W'(1) : b + IDX_W'(1);
                o_tri.odd    = i_walk.half;
                o_tri.is_cap = 1'b0;
                o_tri.last   = !i_cfg.caps && inst_last && i_walk.half
                               && ({1'b0, i_walk.seg} == p_m2);
            end
            PH_BOTTOM: begin
                o_tri.c0     = pole;
                o_tri.c1     = base_n;
                o_tri.c2     = base_i;
                o_tri.odd    = i_walk.inst[0];
                o_tri.is_cap = 1'b1;
                o_tri.last   = 1'b0;
            end
            default: begin  // top cap
                o_tri.c0     = pole + IDX_W'(1);
                o_tri.c1     = base_i + p_x - IDX_W'(1);
                o_tri.c2     = base_n + p_x - IDX_W'(1);
                o_tri.odd    = i_cfg.n[0] ^ i_walk.inst[0];
                o_tri.is_cap = 1'b1;
                o_tri.last   = inst_last;
            end
        endcase
    end

endmodule
